FILE: sv/indexed_sequence_store_unit_defines.svh
// Assertion macros for the indexed sequence store unit.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef INDEXED_SEQUENCE_STORE_UNIT_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ISU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ISU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/isu_pkg.sv
// Shared types and codes for the indexed sequence store unit.
// Used by isu_cell and indexed_sequence_store_unit; depends on nothing.
`default_nettype none

package isu_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_INSERT = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_REMOVE = 3'd4,
    OP_POP    = 3'd5,
    OP_FIND   = 3'd6,
    OP_CLEAR  = 3'd7
  } isu_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } isu_status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } isu_state_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [6:0]  position;
    logic [31:0] element;
  } isu_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic        found;
    logic [5:0]  found_position;
    logic [6:0]  length;
    logic        is_empty;
  } isu_out_t;

  // Update command broadcast to every cell of the row.
  typedef struct packed {
    logic shift_up;    // insert: cells above the position take the left neighbor
    logic shift_down;  // remove: cells at or above the position take the right neighbor
    logic write;       // the cell at the position takes the element
  } isu_cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/isu_cell.sv
// One storage cell of the sequence row: holds one entry, shifts with its neighbors.
// Depends on isu_pkg for the broadcast update command.
`default_nettype none

module isu_cell #(
  parameter int unsigned CELL_INDEX = 0,
  parameter int unsigned CNT_W      = 7,
  parameter int unsigned ELEM_W     = 32
) (
  input  wire                          clk_i,
  input  wire isu_pkg::isu_cell_ctrl_t ctrl_i,
  input  wire logic [CNT_W-1:0]        pos_i,
  input  wire logic [CNT_W-1:0]        count_i,
  input  wire logic [ELEM_W-1:0]       elem_i,
  input  wire logic [ELEM_W-1:0]       left_i,
  input  wire logic [ELEM_W-1:0]       right_i,
  output logic [ELEM_W-1:0]            entry_o,
  output logic                         match_o,
  output logic                         sel_o
);

  localparam logic [CNT_W-1:0] Idx = CNT_W'(CELL_INDEX);

  logic [ELEM_W-1:0] entry_q, entry_d;
  logic              at_pos, above_pos;

  assign at_pos    = (Idx == pos_i);
  assign above_pos = (Idx > pos_i);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift_up) begin
      if (above_pos) begin
        entry_d = left_i;
      end else if (at_pos) begin
        entry_d = elem_i;
      end
    end else if (ctrl_i.shift_down) begin
      if (above_pos || at_pos) begin
        entry_d = right_i;
      end
    end else if (ctrl_i.write && at_pos) begin
      entry_d = elem_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign sel_o   = at_pos;
  // Only live entries take part in a search.
  assign match_o = (entry_q == elem_i) && (Idx < count_i);

endmodule

`default_nettype wire

FILE: sv/indexed_sequence_store_unit.sv
// Top level of the indexed sequence store: command control, the cell row and the result register.
// Depends on isu_pkg, isu_cell and indexed_sequence_store_unit_defines.svh.
`default_nettype none

// Ordered list of up to CAPACITY element handles held in a row of cells. Each command
// is registered in the idle state and carried out in the execute state, in which every
// cell compares and shifts in parallel while the first match and the read entry are
// picked out of the row; no new command is taken while one executes. The result sits
// in an output register; the next command is taken while it waits, and its execute
// cycle holds until the register is free. Entries need no clearing after reset, and
// clear only zeroes the length. The length output shows the low seven bits of the count.
module indexed_sequence_store_unit #(
  parameter int unsigned CAPACITY      = 64,
  parameter int unsigned ELEMENT_WIDTH = 32
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire isu_pkg::isu_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output isu_pkg::isu_out_t      out_data_o
);

`include "indexed_sequence_store_unit_defines.svh"

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned PosW = (CntW > 7) ? CntW : 7;

  isu_pkg::isu_state_e state_q, state_d;
  isu_pkg::isu_in_t    req_q;
  isu_pkg::isu_out_t   out_q, res_d;
  logic                out_valid_q;
  logic [CntW-1:0]     count_q, count_d;

  logic                    accept, exec_done;
  isu_pkg::isu_cell_ctrl_t ctrl, ctrl_live;
  logic [CntW-1:0]         cell_pos;
  logic [ELEMENT_WIDTH-1:0] elem;
  logic [PosW-1:0]         pos_w, cnt_w;
  logic                    full;

  logic [ELEMENT_WIDTH-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]      match, sel, first;
  logic [ELEMENT_WIDTH-1:0] rd_entry;
  logic [IdxW-1:0]          first_idx;

  assign in_ready_o = (state_q == isu_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign exec_done  = (state_q == isu_pkg::S_EXEC) && (!out_valid_q || out_ready_i);

  assign elem  = ELEMENT_WIDTH'(req_q.element);
  assign pos_w = PosW'(req_q.position);
  assign cnt_w = PosW'(count_q);
  assign full  = (count_q == CntW'(CAPACITY));

  // Append works as an insert at the current length.
  assign cell_pos = (isu_pkg::isu_op_e'(req_q.op) == isu_pkg::OP_APPEND) ? count_q
                                                                        : CntW'(req_q.position);

  // Cell row.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEMENT_WIDTH-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = entry_w[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = entry_w[g];
    end else begin : g_inner
      assign right = entry_w[g+1];
    end
    isu_cell #(
      .CELL_INDEX (g),
      .CNT_W      (CntW),
      .ELEM_W     (ELEMENT_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_live),
      .pos_i   (cell_pos),
      .count_i (count_q),
      .elem_i  (elem),
      .left_i  (left),
      .right_i (right),
      .entry_o (entry_w[g]),
      .match_o (match[g]),
      .sel_o   (sel[g])
    );
  end

  // Lowest set match bit, isolated by two's complement.
  assign first = match & (~match + CAPACITY'(1));

  always_comb begin
    first_idx = '0;
    rd_entry  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        first_idx = first_idx | IdxW'(i);
      end
      rd_entry = rd_entry | (entry_w[i] & {ELEMENT_WIDTH{sel[i]}});
    end
  end

  // Command decode and result.
  always_comb begin
    ctrl              = '0;
    count_d           = count_q;
    res_d             = '0;
    res_d.status      = isu_pkg::ST_OK;
    unique case (isu_pkg::isu_op_e'(req_q.op)) inside
      isu_pkg::OP_APPEND: begin
        if (full) begin
          res_d.status = isu_pkg::ST_FULL;
        end else begin
          ctrl.shift_up = 1'b1;
          count_d       = count_q + CntW'(1);
        end
      end
      isu_pkg::OP_INSERT: begin
        if (pos_w > cnt_w) begin
          res_d.status = isu_pkg::ST_RANGE;
        end else if (full) begin
          res_d.status = isu_pkg::ST_FULL;
        end else begin
          ctrl.shift_up = 1'b1;
          count_d       = count_q + CntW'(1);
        end
      end
      isu_pkg::OP_READ, isu_pkg::OP_WRITE, isu_pkg::OP_REMOVE, isu_pkg::OP_POP: begin
        if (pos_w >= cnt_w) begin
          res_d.status = isu_pkg::ST_RANGE;
        end else begin
          if (isu_pkg::isu_op_e'(req_q.op) == isu_pkg::OP_READ ||
              isu_pkg::isu_op_e'(req_q.op) == isu_pkg::OP_POP) begin
            res_d.read_value = 32'(64'(rd_entry));
          end
          if (isu_pkg::isu_op_e'(req_q.op) == isu_pkg::OP_WRITE) begin
            ctrl.write = 1'b1;
          end
          if (isu_pkg::isu_op_e'(req_q.op) == isu_pkg::OP_REMOVE ||
              isu_pkg::isu_op_e'(req_q.op) == isu_pkg::OP_POP) begin
            ctrl.shift_down = 1'b1;
            count_d         = count_q - CntW'(1);
          end
        end
      end
      isu_pkg::OP_FIND: begin
        res_d.found = |match;
        if (|match) begin
          res_d.found_position = 6'(first_idx);
        end
      end
      isu_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
        count_d = count_q;
      end
    endcase
    res_d.length   = 7'(count_d);
    res_d.is_empty = (count_d == '0);
  end

  // Cells only update in the cycle that completes the command.
  assign ctrl_live = exec_done ? ctrl : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      isu_pkg::S_IDLE: begin
        if (accept) begin
          state_d = isu_pkg::S_EXEC;
        end
      end
      isu_pkg::S_EXEC: begin
        if (exec_done) begin
          state_d = isu_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = isu_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isu_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (exec_done) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
    end
    if (exec_done) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ISU_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY),
    "count exceeds capacity")
  `ISU_ASSERT_NEXT(a_done_gives_result, exec_done, out_valid_q,
    "completed command left no result")
  `ISU_ASSERT_NEXT(a_count_hold, !exec_done, $stable(count_q),
    "count changed outside a completing command")
  `ISU_ASSERT_NOW(a_full_only_when_full,
    exec_done && (res_d.status == isu_pkg::ST_FULL), full,
    "store-full status with free room")

endmodule

`default_nettype wire
